FILE: rtl/byte_ring_buffer_top_assert.svh
// assertion macros shared by the byte ring buffer checkers
`ifndef BYTE_RING_BUFFER_TOP_ASSERT_SVH
`define BYTE_RING_BUFFER_TOP_ASSERT_SVH
// same-cycle implication, sampled on clock, off during reset
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, sampled on clock, off during reset
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/brb_pkg.sv
// shared types and constants for the byte ring buffer
`timescale 1ns / 1ps
package brb_pkg;

   localparam int DEPTH_DEFAULT = 4096;
   localparam int CAP_W         = 13;
   localparam int CAP_LIMIT     = 2 ** CAP_W - 1;
   localparam int CAP_RESET     = 4096;
   localparam int OP_W          = 3;
   localparam int BYTE_W        = 8;
   localparam int OFS_W         = 12;
   localparam int CNT_W         = 12;
   localparam int STAT_W        = 3;
   localparam int FILL_W        = 12;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;
   localparam int QDEPTH        = 4;   // power of two

   // request beat layout
   localparam int REQ_OP_LO  = 0;
   localparam int REQ_BY_LO  = REQ_OP_LO + OP_W;
   localparam int REQ_OFS_LO = REQ_BY_LO + BYTE_W;
   localparam int REQ_CNT_LO = REQ_OFS_LO + OFS_W;
   localparam int REQ_BITS   = REQ_CNT_LO + CNT_W;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_BY_LO   = 0;
   localparam int RSP_ST_LO   = RSP_BY_LO + BYTE_W;
   localparam int RSP_FILL_LO = RSP_ST_LO + STAT_W;
   localparam int RSP_EMP_LO  = RSP_FILL_LO + FILL_W;
   localparam int RSP_W       = ((RSP_EMP_LO + 1 + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_STAGE   = 3'd0,
      OP_COMMIT  = 3'd1,
      OP_DISCARD = 3'd2,
      OP_PEEK    = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_ROOM    = 3'd1,
      ST_REFUSED    = 3'd2,
      ST_OVERRUN    = 3'd3,
      ST_PEEK_RANGE = 3'd4
   } status_type;

   localparam logic [CSR_AW-3:0] REG_CAPACITY = '0;

   // one classified operation handed from front to back
   typedef struct packed {
      logic              wr;
      logic              rd;
      logic [CAP_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
      status_type        status;
      logic [FILL_W-1:0] fill;
      logic              empty;
   } cmd_type;

endpackage

FILE: rtl/brb_front.sv
// front end: pointer bookkeeping, capacity register and operation classification
`timescale 1ns / 1ps
module brb_front import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
   localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
   localparam int PTR_W   = $clog2(CAP_MAX);
   // pointers and offsets never exceed the capacity width, one spare bit for sums
   localparam int CW      = CAP_W + 1;

   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  fill_ff, fill_in;
   logic [CAP_W-1:0]  cap_ff, cap_cfg;

   op_type            op;
   logic [OFS_W-1:0]  offset;
   logic [CNT_W-1:0]  count;
   logic              fire, cfg_wr, reg_hit;
   logic [CW-1:0]     capx, fillx, room, lim, offx, cntx, sum;
   logic [PTR_W-1:0]  base, idx;
   logic [CW-1:0]     amt;
   status_type        status;
   logic              do_wr, do_rd;

   assign op     = op_type'(req_tdata[REQ_OP_LO +: OP_W]);
   assign offset = req_tdata[REQ_OFS_LO +: OFS_W];
   assign count  = req_tdata[REQ_CNT_LO +: CNT_W];

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign q_push     = fire;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_AW-1:2] == REG_CAPACITY);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit;
   assign csr_prdata = reg_hit ? CSR_DW'(cap_ff) : '0;

   always_comb begin
      cap_cfg = csr_pwdata[CAP_W-1:0];
      if (cap_cfg < CAP_W'(2)) begin
         cap_cfg = CAP_W'(2);
      end else if (cap_cfg > CAP_W'(CAP_MAX)) begin
         cap_cfg = CAP_W'(CAP_MAX);
      end
   end

   assign capx  = CW'(cap_ff);
   assign fillx = CW'(fill_ff);
   assign lim   = capx - CW'(1);
   assign room  = lim - fillx;
   assign offx  = CW'(offset);
   assign cntx  = CW'(count);

   // one shared wrap adder: every caller keeps base + amount below twice capacity
   assign base = (op == OP_STAGE || op == OP_COMMIT) ? wr_ptr_ff : rd_ptr_ff;
   assign amt  = (op == OP_STAGE || op == OP_PEEK) ? offx : cntx;
   assign sum  = CW'(base) + amt;
   assign idx  = (sum >= capx) ? PTR_W'(sum - capx) : PTR_W'(sum);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      status    = ST_OK;
      do_wr     = 1'b0;
      do_rd     = 1'b0;
      case (op)
         OP_STAGE: begin
            if (offx >= room) status = ST_NO_ROOM;
            else do_wr = 1'b1;
         end
         OP_COMMIT: begin
            if (cntx > room) begin
               status = ST_NO_ROOM;
            end else begin
               wr_ptr_in = idx;
               fill_in   = PTR_W'(fillx + cntx);
            end
         end
         OP_DISCARD: begin
            if (cntx > lim) begin
               status = ST_REFUSED;
            end else if (cntx > fillx) begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               fill_in   = '0;
               status    = ST_OVERRUN;
            end else begin
               rd_ptr_in = idx;
               fill_in   = PTR_W'(fillx - cntx);
            end
         end
         OP_PEEK: begin
            if (offx >= fillx) status = ST_PEEK_RANGE;
            else do_rd = 1'b1;
         end
         OP_CLEAR: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            fill_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      q_cmd.wr     = do_wr;
      q_cmd.rd     = do_rd;
      q_cmd.addr   = CAP_W'(idx);
      q_cmd.data   = req_tdata[REQ_BY_LO +: BYTE_W];
      q_cmd.status = status;
      q_cmd.fill   = FILL_W'(fill_in);
      q_cmd.empty  = (fill_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         cap_ff    <= CAP_W'(CAP_RST);
      end else if (cfg_wr) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         cap_ff    <= cap_cfg;
      end else if (fire) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/brb_queue.sv
// short command queue between the front and back ends
`timescale 1ns / 1ps
module brb_queue import brb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int QAW = $clog2(QDEPTH);

   cmd_type          slots_ff [QDEPTH];
   logic [QAW-1:0]   wr_idx_ff, rd_idx_ff;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (QAW + 1)'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slots_ff[rd_idx_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_idx_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_idx_ff <= wr_idx_ff + 1'b1;
         if (do_pop) rd_idx_ff <= rd_idx_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/brb_back.sv
// back end: byte store access and registered response beat
`timescale 1ns / 1ps
module brb_back import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  cmd_type          pop_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
   localparam int PTR_W   = $clog2(CAP_MAX);

   logic [BYTE_W-1:0] store_mem [CAP_MAX];
   logic [BYTE_W-1:0] rd_byte_ff;
   cmd_type           meta_ff;
   logic              valid_ff;
   logic [PTR_W-1:0]  addr;
   logic [BYTE_W-1:0] byte_out;

   assign addr = pop_cmd.addr[PTR_W-1:0];
   // take the next command when the response register is free or draining
   assign pop  = pop_valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (pop && pop_cmd.wr) store_mem[addr] <= pop_cmd.data;
      if (pop) begin
         rd_byte_ff <= store_mem[addr];
         meta_ff    <= pop_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign byte_out   = meta_ff.rd ? rd_byte_ff : '0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_W'({meta_ff.empty, meta_ff.fill, meta_ff.status, byte_out});

endmodule

FILE: rtl/byte_ring_buffer_top.sv
// top level of the byte ring buffer
`timescale 1ns / 1ps
// Byte ring buffer over a store of up to DEPTH bytes, of which capacity are in
// use; one slot stays empty so at most capacity-1 bytes are held.
// req channel: one beat per operation (stage, commit, discard, peek, clear).
// rsp channel: exactly one beat per request, in request order, carrying the
// peeked byte, a status code, the fill level and an empty flag.
// csr port: capacity register at address 0 (clamped to 2..min(DEPTH, 8191));
// writing it empties the ring. Write it only while no request is outstanding.
// Requests pass the command queue, then the response register. Throughput is one
// operation per cycle unless rsp stalls: the front end's pointer update and wrap
// adder finish in the accept cycle; the back end does one store access per cycle.
// A 4-entry command queue sits between front and back; a stalled rsp channel
// fills it and then drops req_tready, without losing or repeating beats.
// Reset empties the ring, sets capacity to min(4096, DEPTH) and drops all
// queued work. Store contents are not cleared; only committed bytes may be read.
module byte_ring_buffer_top import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // op, byte_in, offset, count, zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // byte_out, status, fill_level, is_empty
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cmd_type push_cmd, pop_cmd;
   logic    push, full, pop, pop_valid;

   brb_front #(.DEPTH(DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_full      (full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   brb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   brb_back #(.DEPTH(DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/brb_port_check.sv
// port-level checks for the byte ring buffer, bound to the top level
`timescale 1ns / 1ps
`include "byte_ring_buffer_top_assert.svh"
module brb_port_check import brb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_W-1:0]  req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [CSR_AW-1:0] csr_paddr,
   input logic [CSR_DW-1:0] csr_pwdata,
   input logic [CSR_DW-1:0] csr_prdata,
   input logic              csr_pready
);

   `BRB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped")
   `BRB_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp beat changed")
   `BRB_ASSERT_NOW(a_empty_fill, rsp_tvalid && rsp_tdata[RSP_EMP_LO], rsp_tdata[RSP_FILL_LO +: FILL_W] == '0, "empty with bytes held")
   `BRB_ASSERT_NOW(a_byte_zero, rsp_tvalid && (rsp_tdata[RSP_ST_LO +: STAT_W] != ST_OK), rsp_tdata[RSP_BY_LO +: BYTE_W] == '0, "byte on failed op")
   `BRB_ASSERT_NOW(a_overrun_empty, rsp_tvalid && (rsp_tdata[RSP_ST_LO +: STAT_W] == ST_OVERRUN), rsp_tdata[RSP_EMP_LO], "overrun left data")

endmodule

bind byte_ring_buffer_top brb_port_check u_port_check (.*);
